// ===== design/qfds_pkg.sv =====
// shared constants for the quick-find disjoint-set block
// no dependencies; imported by quick_find_disjoint_set
package qfds_pkg;

    localparam int QFDS_MAX_VERTICES = 256;

    // field widths fixed by the stream format
    localparam int ACT_W    = 2;
    localparam int VTX_W    = 8;
    localparam int CFG_W    = 9;
    localparam int SETCNT_W = 9;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // action codes; the unused code behaves as a query
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UNITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_RD_A   = 8'b0000_0100,
        ST_RD_B   = 8'b0000_1000,
        ST_EVAL   = 8'b0001_0000,
        ST_WALK   = 8'b0010_0000,
        ST_CLEAR  = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } qfds_state_t;

endpackage

// ===== design/quick_find_disjoint_set.sv =====
// quick-find disjoint-set table: label memory, one shared label comparator, sequencer
// depends on qfds_pkg
//
// channel  | dir | handshake           | payload
// ---------+-----+---------------------+------------------------------------------------
// s        | in  | s_tvalid / s_tready | tuser: action; tdata: vertex_a, vertex_b
// m        | out | m_tvalid / m_tready | tdata: same_set, in_range, merged, set_count
// cfg      | in  | cfg_valid/cfg_ready | cfg_data: vertex_count (used at clear)
//
// query or non-merging unite: states RD_A, RD_B, EVAL, RESULT (two label reads on one port)
// merging unite: the walk reads one memory entry per cycle over every active vertex
// clear: rewriting one entry per cycle up to the new vertex count
// after reset the first min(256, MAX_VERTICES) entries are swept before s_tready rises
// a result waiting on m_tready holds the sequencer in its last state; the next input
// transfer can be taken as soon as the result register is loaded
module quick_find_disjoint_set #(
    parameter int MAX_VERTICES = qfds_pkg::QFDS_MAX_VERTICES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] vertex_a, [15:8] vertex_b
    input  logic [qfds_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] action
    input  logic [qfds_pkg::ACT_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] same_set, [1] in_range, [2] merged, [11:3] set_count, [15:12] zero
    output logic [qfds_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qfds_pkg::CFG_W-1:0]    cfg_data
);
    import qfds_pkg::*;

    localparam int IDX_W      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W      = $clog2(MAX_VERTICES + 1);
    localparam int ACTIVE_RST = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            if (w == 32'd0)
            begin
                w = 32'd1;
            end
            else if (w > 32'(MAX_VERTICES))
            begin
                w = 32'(MAX_VERTICES);
            end
            return CNT_W'(w);
        end
    endfunction

    qfds_state_t             state_reg, state_next;
    logic [CFG_W-1:0]        cfg_reg, cfg_next;
    logic [CNT_W-1:0]        active_reg, active_next;
    logic [SETCNT_W-1:0]     sets_reg, sets_next;
    logic [ACT_W-1:0]        act_reg, act_next;
    logic [VTX_W-1:0]        va_reg, va_next;
    logic [VTX_W-1:0]        vb_reg, vb_next;
    logic                    ok_reg, ok_next;
    logic                    same_reg, same_next;
    logic                    merged_reg, merged_next;
    logic [IDX_W-1:0]        label_a_reg, label_a_next;
    logic [IDX_W-1:0]        label_b_reg, label_b_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        chk_idx_reg, chk_idx_next;
    logic                    chk_vld_reg, chk_vld_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    // label memory
    logic [IDX_W-1:0]        label_mem [MAX_VERTICES];
    logic [IDX_W-1:0]        rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        wr_data;

    logic                    in_xfer;
    logic                    cmp_eq;
    logic                    out_free;
    logic [CNT_W-1:0]        new_count;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign new_count = clamp_count(cfg_reg);

    // the one comparator: source label against the label just read
    assign cmp_eq = (label_a_reg == rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            label_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= label_mem[rd_addr];
    end

    always_comb
    begin
        unique case (state_reg)
            ST_RD_A: rd_addr = IDX_W'(va_reg);
            ST_RD_B: rd_addr = IDX_W'(vb_reg);
            default: rd_addr = idx_reg[IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cfg_next      = cfg_reg;
        active_next   = active_reg;
        sets_next     = sets_reg;
        act_next      = act_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        ok_next       = ok_reg;
        same_next     = same_reg;
        merged_next   = merged_reg;
        label_a_next  = label_a_reg;
        label_b_next  = label_b_reg;
        idx_next      = idx_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = chk_vld_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg[IDX_W-1:0];
        wr_data       = IDX_W'(idx_reg);

        if (cfg_valid && cfg_ready)
        begin
            cfg_next = cfg_data;
        end

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
                if (idx_next == active_reg)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RESULT;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    act_next   = s_tuser;
                    va_next    = s_tdata[VTX_W-1:0];
                    vb_next    = s_tdata[2*VTX_W-1:VTX_W];
                    ok_next    = (32'(s_tdata[VTX_W-1:0]) < 32'(active_reg))
                              && (32'(s_tdata[2*VTX_W-1:VTX_W]) < 32'(active_reg));
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A:
            begin
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                label_a_next = rd_data_reg;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                label_b_next = rd_data_reg;
                same_next    = ok_reg && cmp_eq;
                merged_next  = 1'b0;
                idx_next     = '0;
                chk_vld_next = 1'b0;
                if (act_reg == ACT_UNITE && ok_reg && !cmp_eq)
                begin
                    merged_next = 1'b1;
                    if (sets_reg != '0)
                    begin
                        sets_next = sets_reg - SETCNT_W'(1);
                    end
                    state_next = ST_WALK;
                end
                else if (act_reg == ACT_CLEAR)
                begin
                    active_next = new_count;
                    sets_next   = SETCNT_W'(new_count);
                    state_next  = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_WALK:
            begin
                // read entry idx while checking the previously read entry at chk_idx
                wr_en   = chk_vld_reg && cmp_eq;
                wr_addr = chk_idx_reg;
                wr_data = label_b_reg;
                if (idx_reg < active_reg)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg)
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_DATA_W-SETCNT_W-3){1'b0}}, sets_reg,
                                     merged_reg, ok_reg, same_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cfg_reg      <= CFG_W'(256);
            active_reg   <= CNT_W'(ACTIVE_RST);
            sets_reg     <= SETCNT_W'(ACTIVE_RST);
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            active_reg   <= active_next;
            sets_reg     <= sets_next;
            idx_reg      <= idx_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        ok_reg      <= ok_next;
        same_reg    <= same_next;
        merged_reg  <= merged_next;
        label_a_reg <= label_a_next;
        label_b_reg <= label_b_next;
        chk_idx_reg <= chk_idx_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_sets_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sets_reg) <= 32'(active_reg))
        else $error("set count above active vertex count");

    a_merge_only_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2] && (!m_tdata[1] || m_tdata[0])))
        else $error("merge reported for out-of-range or already joined vertices");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg <= active_reg))
        else $error("walk index ran past the active count");

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_RD_A))
        else $error("accepted transfer did not start the label reads");
`endif

endmodule
